// File: rtl/rbi_pkg.sv
// ----------------------------------------------------------------------------
// rbi_pkg
// Shared widths, constants and types of the ray versus box test.
// ----------------------------------------------------------------------------
package rbi_pkg;

  localparam int AXES       = 3;
  localparam int AX_IDX_W   = $clog2(AXES);
  localparam int COORD_W    = 32;
  localparam int FRAC_BITS  = 16;
  // magnitude of plane - origin needs one bit more than a coordinate
  localparam int MAG_W      = COORD_W + 1;
  // quotient bits kept before saturation
  localparam int Q_BITS     = COORD_W + 1;
  localparam int DVD_W      = MAG_W + FRAC_BITS;
  localparam int CMP_W      = COORD_W + Q_BITS;
  localparam int DIV_STAGES = Q_BITS;
  // prep register, one register per quotient bit, result register
  localparam int LANE_LAT   = DIV_STAGES + 2;
  // lane, two merge registers, output register
  localparam int PIPE_LAT   = LANE_LAT + 3;
  localparam int PROD_W     = 2 * COORD_W;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t T_NONE    = coord_t'(-(longint'(1) << FRAC_BITS));
  localparam logic [Q_BITS:0] NEG_LIM = (Q_BITS+1)'(1) << (COORD_W-1);
  localparam logic [Q_BITS:0] POS_LIM = NEG_LIM - (Q_BITS+1)'(1);

  typedef struct packed {
    coord_t               lo;
    coord_t               hi;
    coord_t               org;
    coord_t               dir;
    coord_t               plane;
    logic [COORD_W-1:0]   den;
    logic                 outside;
    logic                 neg;
    logic                 deg;
    logic                 ovf;
  } lane_side_t;

  typedef struct packed {
    coord_t t;
    coord_t lo;
    coord_t hi;
    coord_t org;
    coord_t dir;
    coord_t plane;
    logic   outside;
  } lane_res_t;

endpackage

// File: rtl/rbi_lane.sv
// ----------------------------------------------------------------------------
// rbi_lane
// One axis: candidate plane and pipelined restoring division giving the
// saturated Q16.16 distance to that plane, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rbi_lane (
  input  logic              clk_i,
  input  logic              en_i,
  input  rbi_pkg::coord_t   lo_i,
  input  rbi_pkg::coord_t   hi_i,
  input  rbi_pkg::coord_t   org_i,
  input  rbi_pkg::coord_t   dir_i,
  output rbi_pkg::lane_res_t res_o
);
  import rbi_pkg::*;

  logic [DVD_W-1:0]  rem_q  [DIV_STAGES+1];
  logic [Q_BITS-1:0] quo_q  [DIV_STAGES+1];
  lane_side_t        side_q [DIV_STAGES+1];

  lane_side_t        side_d;
  logic signed [MAG_W-1:0] num;
  logic [MAG_W-1:0]  num_mag;
  logic [MAG_W-1:0]  num_top;

  always_comb begin
    side_d.lo  = lo_i;
    side_d.hi  = hi_i;
    side_d.org = org_i;
    side_d.dir = dir_i;
    if (org_i < lo_i) begin
      side_d.plane   = lo_i;
      side_d.outside = 1'b1;
    end else if (org_i > hi_i) begin
      side_d.plane   = hi_i;
      side_d.outside = 1'b1;
    end else begin
      side_d.plane   = org_i;
      side_d.outside = 1'b0;
    end
    num     = MAG_W'(side_d.plane) - MAG_W'(org_i);
    num_mag = num[MAG_W-1] ? MAG_W'(-num) : MAG_W'(num);
    side_d.den = dir_i[COORD_W-1] ? COORD_W'(-dir_i) : COORD_W'(dir_i);
    side_d.neg = num[MAG_W-1] ^ dir_i[COORD_W-1];
    side_d.deg = !side_d.outside || (dir_i == '0);
    // quotient would need more than Q_BITS bits
    num_top    = num_mag >> (Q_BITS - FRAC_BITS);
    side_d.ovf = num_top >= MAG_W'(side_d.den);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= {num_mag, {FRAC_BITS{1'b0}}};
      quo_q[0]  <= '0;
      side_q[0] <= side_d;
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    localparam int J = Q_BITS - 1 - s;
    logic [CMP_W-1:0] trial;
    logic [CMP_W-1:0] rem_ext;
    logic             take;

    assign trial   = CMP_W'(side_q[s].den) << J;
    assign rem_ext = CMP_W'(rem_q[s]);
    assign take    = rem_ext >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= take ? DVD_W'(rem_ext - trial) : rem_q[s];
        quo_q[s+1]  <= quo_q[s] | (Q_BITS'(take) << J);
        side_q[s+1] <= side_q[s];
      end
    end
  end

  lane_side_t       fin;
  logic [Q_BITS:0]  mag;
  coord_t           t_d;
  lane_res_t        res_q;

  assign fin = side_q[DIV_STAGES];

  always_comb begin
    // floor toward minus infinity bumps the magnitude of a negative quotient
    mag = {1'b0, quo_q[DIV_STAGES]}
        + (Q_BITS+1)'(fin.neg && (rem_q[DIV_STAGES] != '0));
    if (fin.deg) begin
      t_d = T_NONE;
    end else if (fin.ovf) begin
      t_d = fin.neg ? COORD_MIN : COORD_MAX;
    end else if (fin.neg) begin
      t_d = (mag > NEG_LIM) ? COORD_MIN : coord_t'(-mag[COORD_W-1:0]);
    end else begin
      t_d = (mag > POS_LIM) ? COORD_MAX : coord_t'(mag[COORD_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q.t       <= t_d;
      res_q.lo      <= fin.lo;
      res_q.hi      <= fin.hi;
      res_q.org     <= fin.org;
      res_q.dir     <= fin.dir;
      res_q.plane   <= fin.plane;
      res_q.outside <= fin.outside;
    end
  end

  assign res_o = res_q;

endmodule

// File: rtl/rbi_merge.sv
// ----------------------------------------------------------------------------
// rbi_merge
// Combines the lanes: picks the winning plane, steps the ray to it and
// checks the point against the box.
// ----------------------------------------------------------------------------
module rbi_merge (
  input  logic               clk_i,
  input  logic               en_i,
  input  rbi_pkg::lane_res_t lanes_i [rbi_pkg::AXES],
  output logic               hit_o,
  output logic               inside_o,
  output rbi_pkg::coord_t    point_o [rbi_pkg::AXES]
);
  import rbi_pkg::*;

  // select winner
  coord_t              best_d;
  logic [AX_IDX_W-1:0] win_d;
  logic                inside_d;

  always_comb begin
    best_d   = lanes_i[0].t;
    win_d    = '0;
    inside_d = 1'b1;
    for (int i = 1; i < AXES; i++) begin
      if (best_d < lanes_i[i].t) begin
        best_d = lanes_i[i].t;
        win_d  = AX_IDX_W'(i);
      end
    end
    for (int i = 0; i < AXES; i++) begin
      if (lanes_i[i].outside) inside_d = 1'b0;
    end
  end

  coord_t              best_q;
  logic [AX_IDX_W-1:0] win_q,    win2_q;
  logic                inside_q, inside2_q;
  logic                miss2_q;
  lane_res_t           ln_q  [AXES];
  lane_res_t           ln2_q [AXES];
  logic signed [PROD_W-1:0] prod_q [AXES];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      best_q    <= best_d;
      win_q     <= win_d;
      inside_q  <= inside_d;
      ln_q      <= lanes_i;
      win2_q    <= win_q;
      inside2_q <= inside_q;
      miss2_q   <= best_q[COORD_W-1];
      ln2_q     <= ln_q;
      for (int i = 0; i < AXES; i++) begin
        prod_q[i] <= PROD_W'(best_q) * PROD_W'(ln_q[i].dir);
      end
    end
  end

  // step to the plane and check the box
  coord_t pt     [AXES];
  logic   in_box [AXES];
  logic   hit;

  for (genvar i = 0; i < AXES; i++) begin : g_pt
    logic signed [PROD_W-1:0]  sh;
    logic [PROD_W-COORD_W:0]   top;
    coord_t                    step;
    logic signed [COORD_W:0]   sum;

    always_comb begin
      sh   = prod_q[i] >>> FRAC_BITS;
      top  = sh[PROD_W-1:COORD_W-1];
      if ((&top) || !(|top)) begin
        step = sh[COORD_W-1:0];
      end else begin
        step = sh[PROD_W-1] ? COORD_MIN : COORD_MAX;
      end
      sum = (COORD_W+1)'(ln2_q[i].org) + (COORD_W+1)'(step);
      if (win2_q == AX_IDX_W'(i)) begin
        pt[i] = ln2_q[i].plane;
      end else if (sum[COORD_W] != sum[COORD_W-1]) begin
        pt[i] = sum[COORD_W] ? COORD_MIN : COORD_MAX;
      end else begin
        pt[i] = sum[COORD_W-1:0];
      end
      in_box[i] = (pt[i] >= ln2_q[i].lo) && (pt[i] <= ln2_q[i].hi);
    end
  end

  always_comb begin
    hit = !miss2_q;
    for (int i = 0; i < AXES; i++) begin
      if (!in_box[i]) hit = 1'b0;
    end
    if (inside2_q) hit = 1'b1;
    for (int i = 0; i < AXES; i++) begin
      if (!hit) begin
        point_o[i] = '0;
      end else if (inside2_q) begin
        point_o[i] = ln2_q[i].org;
      end else begin
        point_o[i] = pt[i];
      end
    end
  end

  assign hit_o    = hit;
  assign inside_o = inside2_q;

endmodule

// File: rtl/ray_box_intersection.sv
// ----------------------------------------------------------------------------
// ray_box_intersection
// Ray versus axis-aligned box test in Q16.16, one lane per axis.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   box corners, origin, dir
//   out      output     out_valid_o / out_stall_i hit, started_inside, point
//
// one request per cycle while not stalled; each axis runs a divider pipeline
// (one quotient bit per stage), then the merge and output registers.
// the whole pipeline holds while the output register is full and stalled.
// reset clears only the valid bits; no warm-up after reset.
// ----------------------------------------------------------------------------
module ray_box_intersection (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  rbi_pkg::coord_t box_min_x_i,
  input  rbi_pkg::coord_t box_min_y_i,
  input  rbi_pkg::coord_t box_min_z_i,
  input  rbi_pkg::coord_t box_max_x_i,
  input  rbi_pkg::coord_t box_max_y_i,
  input  rbi_pkg::coord_t box_max_z_i,
  input  rbi_pkg::coord_t ray_origin_x_i,
  input  rbi_pkg::coord_t ray_origin_y_i,
  input  rbi_pkg::coord_t ray_origin_z_i,
  input  rbi_pkg::coord_t ray_dir_x_i,
  input  rbi_pkg::coord_t ray_dir_y_i,
  input  rbi_pkg::coord_t ray_dir_z_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            hit_o,
  output logic            started_inside_o,
  output rbi_pkg::coord_t point_x_o,
  output rbi_pkg::coord_t point_y_o,
  output rbi_pkg::coord_t point_z_o
);
  import rbi_pkg::*;

  logic adv;
  logic [PIPE_LAT-1:0] vld_q;

  assign adv        = !vld_q[PIPE_LAT-1] || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  coord_t    lo  [AXES];
  coord_t    hi  [AXES];
  coord_t    org [AXES];
  coord_t    dir [AXES];
  lane_res_t lanes [AXES];

  assign lo  = '{box_min_x_i, box_min_y_i, box_min_z_i};
  assign hi  = '{box_max_x_i, box_max_y_i, box_max_z_i};
  assign org = '{ray_origin_x_i, ray_origin_y_i, ray_origin_z_i};
  assign dir = '{ray_dir_x_i, ray_dir_y_i, ray_dir_z_i};

  for (genvar i = 0; i < AXES; i++) begin : g_lane
    rbi_lane u_lane (
      .clk_i (clk_i),
      .en_i  (adv),
      .lo_i  (lo[i]),
      .hi_i  (hi[i]),
      .org_i (org[i]),
      .dir_i (dir[i]),
      .res_o (lanes[i])
    );
  end

  logic   hit_d, inside_d;
  coord_t pt_d [AXES];

  rbi_merge u_merge (
    .clk_i    (clk_i),
    .en_i     (adv),
    .lanes_i  (lanes),
    .hit_o    (hit_d),
    .inside_o (inside_d),
    .point_o  (pt_d)
  );

  logic   hit_q, inside_q;
  coord_t pt_q [AXES];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q    <= hit_d;
      inside_q <= inside_d;
      pt_q     <= pt_d;
    end
  end

  assign out_valid_o      = vld_q[PIPE_LAT-1];
  assign hit_o            = hit_q;
  assign started_inside_o = inside_q;
  assign point_x_o        = pt_q[0];
  assign point_y_o        = pt_q[1];
  assign point_z_o        = pt_q[2];

endmodule

// File: rtl/rbi_checker.sv
// ----------------------------------------------------------------------------
// rbi_checker
// Port-level checks of the ray versus box test, bound to the top level.
// ----------------------------------------------------------------------------
module rbi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        hit_o,
  input logic        started_inside_o,
  input logic [31:0] point_x_o,
  input logic [31:0] point_y_o,
  input logic [31:0] point_z_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(hit_o)
      && $stable(point_x_o) && $stable(point_y_o) && $stable(point_z_o))
    else $error("stalled result changed");

  // input only backs up behind a blocked output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back pressure");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> point_x_o == '0 && point_y_o == '0
      && point_z_o == '0)
    else $error("miss with nonzero point");

  a_inside_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && started_inside_o |-> hit_o)
    else $error("origin inside box but no hit");

endmodule

bind ray_box_intersection rbi_checker u_rbi_checker (.*);

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ray versus box test: a directed table of boxes
// and rays, then random rays under several idle and stall phases, each result
// compared with an in-bench predictor in order of acceptance.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rbi_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM       = 1730;

  typedef struct {
    coord_t lo[3];
    coord_t hi[3];
    coord_t org[3];
    coord_t dir[3];
  } ray_req_t;

  typedef struct {
    logic   hit;
    logic   started;
    coord_t pt[3];
  } ray_res_t;

  typedef struct {
    ray_req_t req;
    logic     known;
    ray_res_t res;
  } table_row_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid_i = 1'b0;
  logic   in_stall_o;
  coord_t box_min_x_i = '0, box_min_y_i = '0, box_min_z_i = '0;
  coord_t box_max_x_i = '0, box_max_y_i = '0, box_max_z_i = '0;
  coord_t ray_origin_x_i = '0, ray_origin_y_i = '0, ray_origin_z_i = '0;
  coord_t ray_dir_x_i = '0, ray_dir_y_i = '0, ray_dir_z_i = '0;
  logic   out_valid_o;
  logic   out_stall_i = 1'b0;
  logic   hit_o, started_inside_o;
  coord_t point_x_o, point_y_o, point_z_o;

  ray_box_intersection dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  ray_res_t   expected_q[$];
  table_row_t rows[$];
  int         errors = 0;
  int         n_hits = 0, n_inside = 0, n_results = 0, n_requests = 0;
  int         idle_cycles = 0;
  int         send_idle_pct = 0, stall_pct = 0;

  // ---------------------------------------------------------------- predictor
  function automatic coord_t sat_coord(logic signed [127:0] v);
    if (v > 128'sd2147483647) return COORD_MAX;
    if (v < -128'sd2147483648) return COORD_MIN;
    return coord_t'(v);
  endfunction

  // floor(num * 2^16 / den), saturated
  function automatic coord_t fixed_div(logic signed [63:0] num, coord_t den);
    logic signed [127:0] n, d, q;
    n = 128'(num) <<< FRAC_BITS;
    d = 128'(den);
    q = n / d;
    if ((q * d != n) && ((n < 0) != (d < 0))) q = q - 1;
    return sat_coord(q);
  endfunction

  // floor(x * y / 2^16), saturated
  function automatic coord_t fixed_mul(coord_t x, coord_t y);
    logic signed [127:0] p;
    p = 128'(x) * 128'(y);
    return sat_coord(p >>> FRAC_BITS);
  endfunction

  function automatic ray_res_t predict_hit(ray_req_t r);
    ray_res_t o;
    coord_t   plane[3], t[3], best;
    int       win;
    logic     org_in, hit;
    org_in = 1;
    hit = 1;
    for (int i = 0; i < 3; i++) begin
      if (r.org[i] < r.lo[i]) begin
        plane[i] = r.lo[i];
        org_in = 0;
      end else if (r.org[i] > r.hi[i]) begin
        plane[i] = r.hi[i];
        org_in = 0;
      end else begin
        plane[i] = r.org[i];
      end
    end
    o.pt = '{default: '0};
    if (org_in) begin
      o.pt = r.org;
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (plane[i] == r.org[i] || r.dir[i] == 0) t[i] = T_NONE;
        else t[i] = fixed_div(64'(plane[i]) - 64'(r.org[i]), r.dir[i]);
      end
      win = 0;
      best = t[0];
      for (int i = 1; i < 3; i++) begin
        if (best < t[i]) begin
          win = i;
          best = t[i];
        end
      end
      if (best < 0) hit = 0;
      for (int i = 0; i < 3 && hit; i++) begin
        if (i == win) o.pt[i] = plane[i];
        else o.pt[i] = sat_coord(128'(r.org[i]) + 128'(fixed_mul(best, r.dir[i])));
        if (o.pt[i] < r.lo[i] || o.pt[i] > r.hi[i]) hit = 0;
      end
      if (!hit) o.pt = '{default: '0};
    end
    o.hit = hit;
    o.started = org_in;
    return o;
  endfunction

  // ----------------------------------------------------------------- checking
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      ray_res_t e;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", {31'b0, hit_o}, '0);
      end else begin
        e = expected_q.pop_front();
        n_results++;
        if (e.hit) n_hits++;
        if (e.started) n_inside++;
        if (hit_o !== e.hit) report_mismatch("hit", hit_o, e.hit);
        if (started_inside_o !== e.started)
          report_mismatch("started_inside", started_inside_o, e.started);
        if (point_x_o !== e.pt[0]) report_mismatch("point_x", point_x_o, e.pt[0]);
        if (point_y_o !== e.pt[1]) report_mismatch("point_y", point_y_o, e.pt[1]);
        if (point_z_o !== e.pt[2]) report_mismatch("point_z", point_z_o, e.pt[2]);
      end
    end
  end

  // request acceptance feeds the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      ray_req_t r;
      r.lo  = '{box_min_x_i, box_min_y_i, box_min_z_i};
      r.hi  = '{box_max_x_i, box_max_y_i, box_max_z_i};
      r.org = '{ray_origin_x_i, ray_origin_y_i, ray_origin_z_i};
      r.dir = '{ray_dir_x_i, ray_dir_y_i, ray_dir_z_i};
      expected_q.push_back(predict_hit(r));
      n_requests++;
    end
  end

  // watchdog on cycles with no acceptance on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stall, redrawn each falling edge
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // ---------------------------------------------------------------- stimulus
  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2: return '0;
      3, 4: return coord_t'($urandom);
      default: return coord_t'($signed($urandom_range(40 << 16)) - (20 << 16));
    endcase
  endfunction

  // mostly well-formed boxes with rays aimed at them, some noise
  function automatic ray_req_t rand_request();
    ray_req_t r;
    coord_t a, b, aim;
    int shape;
    shape = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      a = rand_coord();
      b = rand_coord();
      if (shape < 8 && a > b) begin
        r.lo[i] = b;
        r.hi[i] = a;
      end else begin
        r.lo[i] = a;
        r.hi[i] = b;
      end
      r.org[i] = rand_coord();
      if (shape < 6) begin
        // aim at a point between the corners
        aim = coord_t'((64'(r.lo[i]) + 64'(r.hi[i])) >>> 1);
        r.dir[i] = coord_t'((64'(aim) - 64'(r.org[i])) >>> $urandom_range(4));
        if ($urandom_range(7) == 0) r.dir[i] = '0;
      end else begin
        r.dir[i] = rand_coord();
      end
    end
    return r;
  endfunction

  task automatic send_request(ray_req_t r);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    {box_min_x_i, box_min_y_i, box_min_z_i} <= {r.lo[0], r.lo[1], r.lo[2]};
    {box_max_x_i, box_max_y_i, box_max_z_i} <= {r.hi[0], r.hi[1], r.hi[2]};
    {ray_origin_x_i, ray_origin_y_i, ray_origin_z_i} <= {r.org[0], r.org[1], r.org[2]};
    {ray_dir_x_i, ray_dir_y_i, ray_dir_z_i} <= {r.dir[0], r.dir[1], r.dir[2]};
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic void add_row(coord_t lo, coord_t hi, coord_t o[3], coord_t d[3],
                                  logic known, logic h, logic ins, coord_t p[3]);
    table_row_t row;
    row.req.lo = '{lo, lo, lo};
    row.req.hi = '{hi, hi, hi};
    row.req.org = o;
    row.req.dir = d;
    row.known = known;
    row.res.hit = h;
    row.res.started = ins;
    row.res.pt = p;
    rows.push_back(row);
  endfunction

  localparam coord_t ONE = 32'sh0001_0000;

  initial begin
    ray_res_t got;
    coord_t z3[3];
    z3 = '{default: '0};
    // origin inside: hit at the origin
    add_row(-ONE, ONE, '{0, 0, 0}, '{ONE, 0, 0}, 1, 1, 1, '{0, 0, 0});
    // origin on the face counts as inside
    add_row(-ONE, ONE, '{ONE, -ONE, ONE}, z3, 1, 1, 1, '{ONE, -ONE, ONE});
    // full-range box holds every origin
    add_row(COORD_MIN, COORD_MAX, '{COORD_MAX, COORD_MIN, 0}, z3, 1, 1, 1,
            '{COORD_MAX, COORD_MIN, 0});
    // zero direction outside: miss, point zero
    add_row(-ONE, ONE, '{2 * ONE, 0, 0}, z3, 1, 0, 0, z3);
    // pointing away: miss
    add_row(-ONE, ONE, '{2 * ONE, 0, 0}, '{ONE, 0, 0}, 1, 0, 0, z3);
    // straight onto the x face
    add_row(-ONE, ONE, '{3 * ONE, 0, 0}, '{-ONE, 0, 0}, 1, 1, 0, '{ONE, 0, 0});
    add_row(-ONE, ONE, '{0, -3 * ONE, 0}, '{0, ONE, 0}, 1, 1, 0, '{0, -ONE, 0});
    // inverted box never holds anything
    add_row(ONE, -ONE, '{0, 0, 0}, '{ONE, ONE, ONE}, 1, 0, 0, z3);
    // tie between axes, tiny negative quotient, saturations: predictor only
    add_row(-ONE, ONE, '{3 * ONE, 3 * ONE, 0}, '{-ONE, -ONE, 0}, 0, 0, 0, z3);
    add_row(-ONE, ONE, '{2 * ONE, 0, 0}, '{COORD_MAX, 0, 0}, 0, 0, 0, z3);
    add_row(-ONE, ONE, '{COORD_MAX, 0, 0}, '{32'sd1, 32'sd1, 0}, 0, 0, 0, z3);
    add_row(-ONE, ONE, '{COORD_MIN, COORD_MAX, COORD_MIN}, '{32'sd1, -32'sd1, 32'sd1},
            0, 0, 0, z3);
    add_row(COORD_MIN, COORD_MAX, '{0, 0, 0}, '{COORD_MIN, COORD_MAX, -1}, 0, 0, 0, z3);
    add_row(0, 0, '{COORD_MIN, COORD_MIN, COORD_MIN}, '{COORD_MAX, COORD_MAX, COORD_MAX},
            0, 0, 0, z3);
    add_row(-ONE, ONE, '{-4 * ONE, 2 * ONE, ONE / 2}, '{3 * ONE, -ONE, -32'sd7},
            0, 0, 0, z3);
    add_row(32'sh7FFF_0000, COORD_MAX, '{COORD_MIN, 0, 0}, '{COORD_MAX, 0, 0}, 0, 0, 0, z3);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[k]) begin
      if (rows[k].known) begin
        got = predict_hit(rows[k].req);
        if (got.hit !== rows[k].res.hit || got.started !== rows[k].res.started ||
            got.pt != rows[k].res.pt)
          report_mismatch($sformatf("table row %0d", k), got.hit, rows[k].res.hit);
      end
      send_request(rows[k].req);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      case (n * 5 / N_RANDOM)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 68; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 68; end
        3: begin send_idle_pct = 20; stall_pct = 20; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      send_request(rand_request());
    end
    in_valid_i <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 10) @(posedge clk_i);

    $display("%0d rays sent, %0d results checked: %0d hits, %0d started inside",
             n_requests, n_results, n_hits, n_inside);
    $display("phases: free flow, sender gaps, receiver stalls, both mixed");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
